[rtl/pvl_pkg.sv]
// Package for the path vector loop checker: status codes, register indexes
// and the control bundle that drives the node cell chain.
// No dependencies.
package pvl_pkg;

    localparam int NODE_W   = 32;
    localparam int COUNT_W  = 6;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_LOOP      = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic CFG_PEER_ID  = 1'b0;
    localparam logic CFG_LOCAL_ID = 1'b1;

    // Broadcast to every cell of the node chain
    typedef struct packed {
        logic              shift;  // advance the chain, new node enters cell 0
        logic [NODE_W-1:0] probe;  // node under test, also the value shifted in
    } t_cell_ctl;

endpackage

[rtl/pvl_cell.sv]
// One storage cell of the node chain: holds one path node, passes it on to
// its neighbor on shift, and flags a match against the broadcast probe.
// Depends on pvl_pkg.
module pvl_cell
    import pvl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_stored,   // nodes held by the chain
    input  logic [NODE_W-1:0] i_prev,     // node of the upstream neighbor
    output logic [NODE_W-1:0] o_node,
    output logic              o_match
);

    logic [NODE_W-1:0] r_node;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_node <= i_prev;
        end
    end

    // Cell IDX holds a node of this attribute only while the count covers it
    assign o_match = (CW'(IDX) < i_stored) && (r_node == i_ctl.probe);
    assign o_node  = r_node;

endmodule

[rtl/path_vector_loop_checker.sv]
// Path vector loop checker: top level with byte parser, check logic,
// node cell chain and output register.
// Depends on pvl_pkg and pvl_cell.
//
// Usage: feed the path attribute one byte per transaction on the s_axis
// channel, tdata = {originator_id, wire_byte}, tlast on the final byte.
// The originator id is sampled with the first byte of each attribute.
// One status transaction leaves on m_axis per attribute, in the cycle after
// the byte carrying tlast is accepted; other bytes give no output.
// Throughput is one byte per cycle: every node is checked against all
// stored nodes of the chain in parallel in the cycle its fourth byte
// arrives, so a new attribute may follow its predecessor directly.
// The output register holds one status; while it is full and m_axis_tready
// is low, s_axis_tready drops and input stalls. Writing it and taking the
// old status happen in the same cycle, so a draining receiver sees no gap.
// Reset (synchronous, active low) clears the parser, the flags, the output
// valid bit and both id registers. Write peer and local id through the
// config port only while no attribute is in progress.
module path_vector_loop_checker
    import pvl_pkg::*;
#(
    parameter int MAX_PATH_NODES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // attribute byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] wire_byte, [39:8] originator_id
    input  logic        s_axis_tlast,   // last byte of the attribute
    // status stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [7:2] hop_count
);

    localparam int CW = $clog2(MAX_PATH_NODES + 1);

    // Config registers
    logic [NODE_W-1:0] r_peer_id;
    logic [NODE_W-1:0] r_local_id;

    // Per-attribute parser state
    logic [7:0]        r_byte_cnt,   n_byte_cnt;
    logic [15:0]       r_decl_cnt,   n_decl_cnt;
    logic [23:0]       r_word_shift, n_word_shift;
    logic [CW-1:0]     r_stored,     n_stored;
    logic              r_malformed,  n_malformed;
    logic              r_local_seen, n_local_seen;
    logic [NODE_W-1:0] r_held_orig,  n_held_orig;
    logic [NODE_W-1:0] r_first_node, n_first_node;

    // Output register
    logic              r_out_valid;
    t_status           r_out_status, n_out_status;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic              w_accept;
    logic [7:0]        w_byte;
    logic [NODE_W-1:0] w_orig;
    logic              w_hdr_byte;
    logic              w_node_byte;
    logic [NODE_W-1:0] w_node;
    logic              w_cnt_bad;
    logic              w_full;
    logic              w_dup;
    logic              w_take;
    logic              w_node_bad;
    logic              w_len_ok;
    logic              w_bad;
    logic              w_invalid;
    logic              w_loop;

    t_cell_ctl         w_ctl;
    logic [NODE_W-1:0] w_chain [MAX_PATH_NODES];
    logic [MAX_PATH_NODES-1:0] w_match;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_byte   = s_axis_tdata[7:0];
    assign w_orig   = s_axis_tdata[39:8];

    // Take a new byte whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    // Byte position: two count bytes, then 4-byte nodes; the fourth byte of
    // each node sits at positions 5, 9, 13, ...
    assign w_hdr_byte  = (r_byte_cnt < 8'd2);
    assign w_node_byte = !w_hdr_byte && (r_byte_cnt[1:0] == 2'b01);
    assign w_node      = {r_word_shift, w_byte};

    always_comb begin
        n_decl_cnt = w_hdr_byte ? {r_decl_cnt[7:0], w_byte} : r_decl_cnt;
        w_cnt_bad  = (r_byte_cnt == 8'd1) &&
                     ((n_decl_cnt == 16'd0) || (n_decl_cnt > 16'(MAX_PATH_NODES)));

        // Nodes past the declared count or the store depth are dropped
        w_full = (16'(r_stored) >= r_decl_cnt) || (r_stored >= CW'(MAX_PATH_NODES));
        w_dup  = |w_match;
        w_take = w_node_byte && !w_full;
        w_node_bad = w_node_byte && (w_full || (w_node == '0) || w_dup);

        n_local_seen = r_local_seen ||
                       (w_take && (w_node == r_local_id) && (w_node != '0));
        n_stored     = w_take ? r_stored + CW'(1) : r_stored;
        n_byte_cnt   = (r_byte_cnt == 8'hFF) ? r_byte_cnt : r_byte_cnt + 8'd1;

        if (w_node_byte) begin
            n_word_shift = '0;
        end else if (!w_hdr_byte) begin
            n_word_shift = {r_word_shift[15:0], w_byte};
        end else begin
            n_word_shift = r_word_shift;
        end

        n_malformed  = r_malformed || w_cnt_bad || w_node_bad;
        n_held_orig  = (r_byte_cnt == 8'd0) ? w_orig : r_held_orig;
        n_first_node = (w_take && (r_stored == '0)) ? w_node : r_first_node;

        // Total length must be 2 + 4 * count; a saturated counter is odd
        w_len_ok = (n_byte_cnt >= 8'd2) &&
                   ({10'd0, n_byte_cnt} == {n_decl_cnt, 2'b10});
        w_bad    = n_malformed || !w_len_ok || (n_stored == '0);

        // When well formed the final byte completed the last node, so that
        // node is the one compared against the peer
        w_invalid = (n_held_orig == '0) || (r_peer_id == '0) || (r_local_id == '0);
        w_loop    = (n_first_node != n_held_orig) || (w_node != r_peer_id) ||
                    n_local_seen;

        if (w_bad) begin
            n_out_status = ST_MALFORMED;
            n_out_count  = '0;
        end else begin
            n_out_count = COUNT_W'(n_stored);
            if (w_invalid) begin
                n_out_status = ST_INVALID;
            end else if (w_loop) begin
                n_out_status = ST_LOOP;
            end else begin
                n_out_status = ST_OK;
            end
        end
    end

    // Node chain: a stored node moves one cell down per new node, and every
    // cell compares its node with the incoming one
    assign w_ctl.shift = w_accept && w_take;
    assign w_ctl.probe = w_node;

    for (genvar g = 0; g < MAX_PATH_NODES; g++) begin : g_cell
        pvl_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_stored (r_stored),
            .i_prev   ((g == 0) ? w_node : w_chain[(g == 0) ? 0 : g - 1]),
            .o_node   (w_chain[g]),
            .o_match  (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_id    <= '0;
            r_local_id   <= '0;
            r_byte_cnt   <= '0;
            r_decl_cnt   <= '0;
            r_word_shift <= '0;
            r_stored     <= '0;
            r_malformed  <= 1'b0;
            r_local_seen <= 1'b0;
            r_held_orig  <= '0;
            r_first_node <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_PEER_ID:  r_peer_id  <= i_cfg_wdata;
                    CFG_LOCAL_ID: r_local_id <= i_cfg_wdata;
                endcase
            end

            if (w_accept) begin
                if (s_axis_tlast) begin
                    // Drop all attribute state for the next attribute
                    r_byte_cnt   <= '0;
                    r_decl_cnt   <= '0;
                    r_word_shift <= '0;
                    r_stored     <= '0;
                    r_malformed  <= 1'b0;
                    r_local_seen <= 1'b0;
                    r_held_orig  <= '0;
                    r_first_node <= '0;
                end else begin
                    r_byte_cnt   <= n_byte_cnt;
                    r_decl_cnt   <= n_decl_cnt;
                    r_word_shift <= n_word_shift;
                    r_stored     <= n_stored;
                    r_malformed  <= n_malformed;
                    r_local_seen <= n_local_seen;
                    r_held_orig  <= n_held_orig;
                    r_first_node <= n_first_node;
                end
            end

            if (w_accept && s_axis_tlast) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status payload, loaded with the final byte
    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tlast) begin
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_status};

endmodule

[rtl/pvl_checker.sv]
// Port-level assertions for the path vector loop checker, bound to the
// top level. Depends on pvl_pkg.
module pvl_checker
    import pvl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // Hold a stalled status transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("status changed while stalled");

    // Every accepted final byte yields a status in the next cycle
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no status after final byte");

    // Input never stalls while the output register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A malformed attribute reports no nodes
    a_malformed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_MALFORMED) |->
            (m_axis_tdata[7:2] == 6'd0))
        else $error("malformed status with nonzero node count");

    // A well-formed attribute holds at least one node
    a_wellformed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ST_MALFORMED) |->
            (m_axis_tdata[7:2] != 6'd0))
        else $error("well-formed status with zero node count");

endmodule

bind path_vector_loop_checker pvl_checker u_pvl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
